// ===== design/hrf_pkg.sv =====
package hrf_pkg;

  // Width of the Content-Length accumulator and the body byte counter
  localparam int LENGTH_WIDTH = 32;

  // Parse phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_METHOD  = 4'd1;
  localparam logic [3:0] PH_PATH    = 4'd2;
  localparam logic [3:0] PH_VERSION = 4'd3;
  localparam logic [3:0] PH_HNAME   = 4'd4;
  localparam logic [3:0] PH_HVALUE  = 4'd5;
  localparam logic [3:0] PH_CR      = 4'd6;
  localparam logic [3:0] PH_CRLF    = 4'd7;
  localparam logic [3:0] PH_CRLFCR  = 4'd8;
  localparam logic [3:0] PH_BODY    = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;
  localparam logic [3:0] PH_ERROR   = 4'd11;

  // Content-Length value sub-phases
  localparam logic [1:0] VP_SKIP  = 2'd0;
  localparam logic [1:0] VP_SIGN  = 2'd1;
  localparam logic [1:0] VP_DIGIT = 2'd2;
  localparam logic [1:0] VP_STOP  = 2'd3;

  // Field tags
  localparam logic [2:0] TAG_DELIM   = 3'd0;
  localparam logic [2:0] TAG_METHOD  = 3'd1;
  localparam logic [2:0] TAG_PATH    = 3'd2;
  localparam logic [2:0] TAG_VERSION = 3'd3;
  localparam logic [2:0] TAG_HNAME   = 3'd4;
  localparam logic [2:0] TAG_HVALUE  = 3'd5;
  localparam logic [2:0] TAG_BODY    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [3:0] CL_LEN = 4'd14;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } hrf_item_t;

  typedef struct packed {
    logic        byte_accepted;
    logic [7:0]  byte_out;
    logic [2:0]  field_tag;
    logic        field_end;
    logic [1:0]  status;
    logic [31:0] body_length;
    logic        length_known;
  } hrf_result_t;

  // Characters of "Content-Length", by position
  function automatic logic [7:0] cl_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:  ch = 8'h43; // C
      4'd1:  ch = 8'h6F; // o
      4'd2:  ch = 8'h6E; // n
      4'd3:  ch = 8'h74; // t
      4'd4:  ch = 8'h65; // e
      4'd5:  ch = 8'h6E; // n
      4'd6:  ch = 8'h74; // t
      4'd7:  ch = 8'h2D; // -
      4'd8:  ch = 8'h4C; // L
      4'd9:  ch = 8'h65; // e
      4'd10: ch = 8'h6E; // n
      4'd11: ch = 8'h67; // g
      4'd12: ch = 8'h74; // t
      4'd13: ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/hrf_in_reg.sv =====
module hrf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  hrf_pkg::hrf_item_t s_item,
  input  logic              take,
  output logic              valid,
  output hrf_pkg::hrf_item_t item
);
  import hrf_pkg::*;

  // Refill in the same cycle the held item moves on
  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

// ===== design/hrf_parser.sv =====
module hrf_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  hrf_pkg::hrf_item_t   item,
  output hrf_pkg::hrf_result_t result
);
  import hrf_pkg::*;

  localparam int W = LENGTH_WIDTH;

  logic [3:0]   parse_phase, parse_phase_next;
  logic [3:0]   name_match_pos, name_match_pos_next;
  logic         name_mismatch, name_mismatch_next;
  logic         length_seen, length_seen_next;
  logic [1:0]   value_phase, value_phase_next;
  logic         digit_seen, digit_seen_next;
  logic [W-1:0] length_accum, length_accum_next;
  logic [W-1:0] body_count, body_count_next;

  logic [7:0]   c;
  logic         is_dig, is_ws, hdr_len, name_hit, name_hit_first;
  logic [3:0]   dval;
  logic [W+3:0] acc_ext;
  logic         acc_ovf;
  logic [2:0]   tag;
  logic         fend;
  logic         accepted;

  assign c      = item.data_byte;
  assign is_dig = c inside {[8'h30:8'h39]};
  assign is_ws  = (c == CH_SPACE) || (c inside {[8'h09:8'h0C]});
  assign dval   = 4'(c - CH_ZERO);

  // accum*10 + d as shift-add; any bit above W means overflow
  assign acc_ext = ({4'b0, length_accum} << 3) + ({4'b0, length_accum} << 1)
                 + {{W{1'b0}}, dval};
  assign acc_ovf = |acc_ext[W+3:W];

  assign hdr_len = !name_mismatch && (name_match_pos == CL_LEN) && !length_seen;
  assign name_hit = !name_mismatch && (name_match_pos < CL_LEN)
                  && (c == cl_char(name_match_pos));
  assign name_hit_first = (c == cl_char(4'd0));

  always_comb begin
    parse_phase_next    = parse_phase;
    name_match_pos_next = name_match_pos;
    name_mismatch_next  = name_mismatch;
    length_seen_next    = length_seen;
    value_phase_next    = value_phase;
    digit_seen_next     = digit_seen;
    length_accum_next   = length_accum;
    body_count_next     = body_count;
    tag      = TAG_DELIM;
    fend     = 1'b0;
    accepted = 1'b1;

    if (item.restart) begin
      parse_phase_next    = PH_IDLE;
      name_match_pos_next = '0;
      name_mismatch_next  = 1'b0;
      length_seen_next    = 1'b0;
      value_phase_next    = VP_SKIP;
      digit_seen_next     = 1'b0;
      length_accum_next   = '0;
      body_count_next     = '0;
      accepted            = 1'b0;
    end else if (parse_phase >= PH_DONE) begin
      accepted = 1'b0;
    end else begin
      case (parse_phase)
        PH_IDLE, PH_METHOD, PH_PATH: begin
          if (c == CH_SPACE) begin
            fend = 1'b1;
            parse_phase_next = (parse_phase == PH_PATH) ? PH_VERSION : PH_PATH;
          end else if (c == CH_CR || c == CH_LF) begin
            parse_phase_next = PH_ERROR;
          end else begin
            tag = (parse_phase == PH_PATH) ? TAG_PATH : TAG_METHOD;
            parse_phase_next = (parse_phase == PH_PATH) ? PH_PATH : PH_METHOD;
          end
        end
        PH_VERSION: begin
          if (c == CH_CR) begin
            fend = 1'b1;
            parse_phase_next = PH_CR;
          end else if (c == CH_LF) begin
            parse_phase_next = PH_ERROR;
          end else begin
            tag = TAG_VERSION;
          end
        end
        PH_HNAME: begin
          if (c == CH_COLON) begin
            fend = 1'b1;
            parse_phase_next = PH_HVALUE;
            value_phase_next = VP_SKIP;
          end else if (c == CH_CR || c == CH_LF) begin
            parse_phase_next = PH_ERROR;
          end else begin
            tag = TAG_HNAME;
            if (name_hit) name_match_pos_next = name_match_pos + 4'd1;
            else          name_mismatch_next  = 1'b1;
          end
        end
        PH_HVALUE: begin
          if (c == CH_CR) begin
            if (hdr_len && !digit_seen) begin
              parse_phase_next = PH_ERROR;
            end else begin
              if (hdr_len) length_seen_next = 1'b1;
              fend = 1'b1;
              parse_phase_next = PH_CR;
            end
          end else begin
            tag = TAG_HVALUE;
            if (hdr_len) begin
              case (value_phase)
                VP_SKIP, VP_SIGN, VP_DIGIT: begin
                  if (is_dig) begin
                    if (acc_ovf) begin
                      value_phase_next = VP_STOP;
                      digit_seen_next  = 1'b0;
                    end else begin
                      length_accum_next = acc_ext[W-1:0];
                      digit_seen_next   = 1'b1;
                      value_phase_next  = VP_DIGIT;
                    end
                  end else if (value_phase == VP_DIGIT) begin
                    value_phase_next = VP_STOP;
                  end else if (value_phase == VP_SKIP && is_ws) begin
                    value_phase_next = VP_SKIP;
                  end else if (value_phase == VP_SKIP && c == CH_PLUS) begin
                    value_phase_next = VP_SIGN;
                  end else begin
                    value_phase_next = VP_STOP;
                    digit_seen_next  = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        PH_CR: begin
          parse_phase_next = (c == CH_LF) ? PH_CRLF : PH_ERROR;
        end
        PH_CRLF: begin
          if (c == CH_CR) begin
            parse_phase_next = PH_CRLFCR;
          end else begin
            tag = TAG_HNAME;
            parse_phase_next    = PH_HNAME;
            name_match_pos_next = name_hit_first ? 4'd1 : 4'd0;
            name_mismatch_next  = !name_hit_first;
          end
        end
        PH_CRLFCR: begin
          if (c == CH_LF) begin
            parse_phase_next = (length_seen && (length_accum != '0)) ? PH_BODY : PH_DONE;
          end else begin
            parse_phase_next = PH_ERROR;
          end
        end
        default: begin // body
          tag = TAG_BODY;
          if (body_count < length_accum) body_count_next = body_count + W'(1);
          if (body_count_next == length_accum) parse_phase_next = PH_DONE;
        end
      endcase
      if (parse_phase_next == PH_ERROR) begin
        tag  = TAG_DELIM;
        fend = 1'b0;
      end
    end
  end

  always_comb begin
    result.byte_accepted = accepted;
    result.byte_out      = accepted ? c : 8'h00;
    result.field_tag     = tag;
    result.field_end     = fend;
    result.status        = (parse_phase_next == PH_DONE) ? ST_DONE :
                           (parse_phase_next > PH_DONE)  ? ST_ERROR : ST_RUN;
    result.body_length   = 32'(length_accum_next);
    result.length_known  = length_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_IDLE;
      name_match_pos <= '0;
      name_mismatch  <= 1'b0;
      length_seen    <= 1'b0;
      value_phase    <= VP_SKIP;
      digit_seen     <= 1'b0;
      length_accum   <= '0;
      body_count     <= '0;
    end else if (advance) begin
      parse_phase    <= parse_phase_next;
      name_match_pos <= name_match_pos_next;
      name_mismatch  <= name_mismatch_next;
      length_seen    <= length_seen_next;
      value_phase    <= value_phase_next;
      digit_seen     <= digit_seen_next;
      length_accum   <= length_accum_next;
      body_count     <= body_count_next;
    end
  end

endmodule

// ===== design/hrf_out_reg.sv =====
module hrf_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  hrf_pkg::hrf_result_t result,
  output logic                space,
  output logic                m_valid,
  input  logic                m_ready,
  output hrf_pkg::hrf_result_t m_result
);
  import hrf_pkg::*;

  assign space = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (space) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= result;
    end
  end

endmodule

// ===== design/http_request_framer_core.sv =====
// Channel   Dir  Payload
// s_*       in   tuser[0] restart, tdata[7:0] request byte
// m_*       out  tuser[2:0] field tag, tlast field end, tdata status/length/echo
//
// Each input transfer fills the input register; the item then updates the parser
// state and enters the result register when it has space. One item per cycle
// sustained while m_tready is high; the per-byte parser state update is
// combinational (shift-add times ten plus compare). Reset (rst, synchronous)
// clears both valid flags and all parser state. A stalled m_tready holds the
// result; the input register absorbs one more transfer before s_tready drops.
module http_request_framer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] req_type (1 = restart)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] byte_accepted, [8:1] byte_out, [10:9] status,
                                 // [42:11] body_length, [43] length_known, [47:44] zero
  output logic [2:0]  m_tuser,   // [2:0] field_tag
  output logic        m_tlast    // field_end
);
  import hrf_pkg::*;

  hrf_item_t   s_item, item;
  hrf_result_t result, m_result;
  logic        in_valid, space, advance;

  assign s_item.restart   = s_tuser[0];
  assign s_item.data_byte = s_tdata;

  // Item moves from input register into result register and updates state
  assign advance = in_valid && space;

  hrf_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .take    (advance),
    .valid   (in_valid),
    .item    (item)
  );

  hrf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  hrf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .space    (space),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (m_result)
  );

  assign m_tdata = {4'b0000, m_result.length_known, m_result.body_length,
                    m_result.status, m_result.byte_out, m_result.byte_accepted};
  assign m_tuser = m_result.field_tag;
  assign m_tlast = m_result.field_end;

`ifndef SYNTHESIS
  // A processed item always shows up as a result the next cycle
  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed item did not reach result register");

  // Restart gives an all-zero result
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && item.restart) |=> (m_tdata == '0 && m_tuser == TAG_DELIM && !m_tlast))
    else $error("restart result not cleared");

  // Field end only ever marks a delimiter byte that was consumed
  a_fend_delim: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == TAG_DELIM && m_tdata[0]))
    else $error("field end on non-delimiter");

  // A held input item is not overwritten while the result side is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(item)))
    else $error("held input item lost");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrf_pkg::*;

  // "Content-Length", first character in the top byte
  localparam logic [8*14-1:0] CL_TEXT = "Content-Length";
  // Largest value the length accumulator can hold
  localparam logic [63:0] LEN_LIMIT = {64{1'b1}} >> (64 - LENGTH_WIDTH);
  localparam int N_RANDOM = 1900;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  http_request_framer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Items waiting to be sent, items of the request being built,
  // and the results predicted for accepted items, oldest first.
  hrf_item_t   pending[$];
  hrf_item_t   req[$];
  hrf_result_t tagged_bytes[$];

  int n_total  = 0;
  int n_sent   = 0;
  int n_errors = 0;

  // Shadow parser state
  logic [3:0]  prs_phase;
  logic [3:0]  cl_pos;       // characters of the length header name matched
  bit          cl_miss;      // header name can no longer be Content-Length
  bit          cl_known;     // a Content-Length header has been closed
  logic [1:0]  num_phase;
  bit          got_digit;    // cleared again as the mark of a bad value
  logic [63:0] cl_value;
  logic [63:0] body_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] cl_text_char(input int i);
    return CL_TEXT[8*(13-i) +: 8];
  endfunction

  function automatic void clear_parser();
    prs_phase = PH_IDLE;
    cl_pos    = '0;
    cl_miss   = 1'b0;
    cl_known  = 1'b0;
    num_phase = VP_SKIP;
    got_digit = 1'b0;
    cl_value  = '0;
    body_seen = '0;
  endfunction

  function automatic bit length_header();
    return !cl_miss && cl_pos == CL_LEN && !cl_known;
  endfunction

  function automatic void match_name(input logic [7:0] ch);
    if (!cl_miss && cl_pos < CL_LEN && ch == cl_text_char(cl_pos))
      cl_pos = cl_pos + 4'd1;
    else
      cl_miss = 1'b1;
  endfunction

  // Overflow leaves the value as it was and drops the digit mark
  function automatic void add_digit(input logic [3:0] d);
    if (cl_value > (LEN_LIMIT - d) / 10) begin
      num_phase = VP_STOP;
      got_digit = 1'b0;
    end else begin
      cl_value  = cl_value * 10 + d;
      got_digit = 1'b1;
      num_phase = VP_DIGIT;
    end
  endfunction

  function automatic void length_char(input logic [7:0] ch);
    logic dig;
    dig = ch >= CH_ZERO && ch <= CH_ZERO + 8'd9;
    case (num_phase)
      VP_SKIP: begin
        if (dig) begin
          add_digit(4'(ch - CH_ZERO));
        end else if (!(ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13))) begin
          if (ch == CH_PLUS) begin
            num_phase = VP_SIGN;
          end else begin
            num_phase = VP_STOP;
            got_digit = 1'b0;
          end
        end
      end
      VP_SIGN: begin
        if (dig) begin
          add_digit(4'(ch - CH_ZERO));
        end else begin
          num_phase = VP_STOP;
          got_digit = 1'b0;
        end
      end
      VP_DIGIT: begin
        if (dig) add_digit(4'(ch - CH_ZERO));
        else num_phase = VP_STOP;
      end
      default: ;
    endcase
  endfunction

  // Advances the shadow parser by one item and returns the tagged byte
  function automatic hrf_result_t frame_byte(input logic restart, input logic [7:0] ch);
    hrf_result_t r;
    logic [2:0]  tag;
    logic        fend;
    r    = '0;
    tag  = TAG_DELIM;
    fend = 1'b0;
    if (restart) begin
      clear_parser();
      return r;
    end
    if (prs_phase < PH_DONE) begin
      r.byte_accepted = 1'b1;
      r.byte_out      = ch;
      case (prs_phase)
        PH_IDLE, PH_METHOD, PH_PATH: begin
          if (ch == CH_SPACE) begin
            fend = 1'b1;
            prs_phase = (prs_phase == PH_PATH) ? PH_VERSION : PH_PATH;
          end else if (ch == CH_CR || ch == CH_LF) begin
            prs_phase = PH_ERROR;
          end else begin
            tag = (prs_phase == PH_PATH) ? TAG_PATH : TAG_METHOD;
            if (prs_phase != PH_PATH) prs_phase = PH_METHOD;
          end
        end
        PH_VERSION: begin
          if (ch == CH_CR) begin
            fend = 1'b1;
            prs_phase = PH_CR;
          end else if (ch == CH_LF) begin
            prs_phase = PH_ERROR;
          end else begin
            tag = TAG_VERSION;
          end
        end
        PH_HNAME: begin
          if (ch == CH_COLON) begin
            fend = 1'b1;
            prs_phase = PH_HVALUE;
            num_phase = VP_SKIP;
          end else if (ch == CH_CR || ch == CH_LF) begin
            prs_phase = PH_ERROR;
          end else begin
            tag = TAG_HNAME;
            match_name(ch);
          end
        end
        PH_HVALUE: begin
          if (ch == CH_CR) begin
            if (length_header() && !got_digit) begin
              prs_phase = PH_ERROR;
            end else begin
              if (length_header()) cl_known = 1'b1;
              fend = 1'b1;
              prs_phase = PH_CR;
            end
          end else begin
            tag = TAG_HVALUE;
            if (length_header()) length_char(ch);
          end
        end
        PH_CR: prs_phase = (ch == CH_LF) ? PH_CRLF : PH_ERROR;
        PH_CRLF: begin
          if (ch == CH_CR) begin
            prs_phase = PH_CRLFCR;
          end else begin
            // any other byte opens a header name, a colon included
            tag     = TAG_HNAME;
            cl_pos  = '0;
            cl_miss = 1'b0;
            match_name(ch);
            prs_phase = PH_HNAME;
          end
        end
        PH_CRLFCR: begin
          if (ch == CH_LF)
            prs_phase = (cl_known && cl_value > 0) ? PH_BODY : PH_DONE;
          else
            prs_phase = PH_ERROR;
        end
        default: begin
          tag = TAG_BODY;
          if (body_seen < cl_value) body_seen = body_seen + 1;
          if (body_seen == cl_value) prs_phase = PH_DONE;
        end
      endcase
      if (prs_phase == PH_ERROR) begin
        tag  = TAG_DELIM;
        fend = 1'b0;
      end
    end
    r.field_tag    = tag;
    r.field_end    = fend;
    r.status       = (prs_phase == PH_DONE) ? ST_DONE :
                     (prs_phase > PH_DONE) ? ST_ERROR : ST_RUN;
    r.body_length  = cl_value[31:0];
    r.length_known = cl_known;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  function automatic logic [7:0] rand_byte_not(input logic [7:0] a, b, c);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b || v == c);
    return v;
  endfunction

  task automatic put(input logic [7:0] b);
    req.push_back({1'b0, b});
  endtask

  task automatic put_restart();
    req.push_back({1'b1, 8'($urandom)});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic flush_req();
    foreach (req[i]) pending.push_back(req[i]);
    req.delete();
  endtask

  // Exact header name, or one with the last character dropped, a character
  // replaced, or a character appended.
  task automatic put_length_name(input int variant);
    int p;
    p = $urandom_range(13);
    for (int i = 0; i < 14; i++)
      if (!(variant == 0 && i == 13))
        put((variant == 1 && i == p) ? rand_byte_not(CH_COLON, CH_CR, CH_LF)
                                     : cl_text_char(i));
    if (variant == 2) put(rand_byte_not(CH_COLON, CH_CR, CH_LF));
  endtask

  // Content-Length value; ok is set when it parses cleanly to num
  task automatic put_length_value(output logic [63:0] num, output bit ok);
    int    form;
    int    k;
    string s;
    form = $urandom_range(99);
    ok   = 1'b1;
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(4);
      put(k == 0 ? CH_SPACE : 8'(8 + k));
    end
    if ($urandom_range(3) == 0) put(CH_PLUS);
    if (form < 75) begin
      num = 64'($urandom_range(0, 6));
      s = $sformatf("%0d", num);
      if ($urandom_range(3) == 0) s = {"0", s};
    end else if (form < 85) begin
      // largest legal value, or one past it
      num = 64'hFFFF_FFFF + $urandom_range(0, 1);
      s = $sformatf("%0d", num);
      ok = (num <= LEN_LIMIT);
    end else if (form < 90) begin
      num = 64'd10_000_000_000 + $urandom;
      s = $sformatf("%0d", num);
      ok = 1'b0;
    end else begin
      num = '0;
      ok = 1'b0;
      case ($urandom_range(2))
        0: s = "";
        1: s = "-3";
        default: s = "x7";
      endcase
    end
    put_text(s);
    // trailing junk after the digits is ignored
    if ($urandom_range(3) == 0) put($urandom_range(1) ? CH_SPACE : 8'h78);
  endtask

  task automatic add_request();
    int          n_hdr;
    int          body_n;
    int          pick;
    int          p;
    logic [63:0] num;
    bit          ok;
    bit          cl_taken;
    body_n   = 0;
    cl_taken = 1'b0;
    put_restart();
    repeat ($urandom_range(1, 4)) put(rand_byte_not(CH_SPACE, CH_CR, CH_LF));
    put(CH_SPACE);
    repeat ($urandom_range(0, 4)) put(rand_byte_not(CH_SPACE, CH_CR, CH_LF));
    put(CH_SPACE);
    repeat ($urandom_range(0, 4)) put(rand_byte_not(CH_CR, CH_LF, CH_CR));
    put(CH_CR);
    put(CH_LF);
    n_hdr = $urandom_range(0, 3);
    for (int h = 0; h < n_hdr; h++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        put_length_name(3);
        put(CH_COLON);
        put_length_value(num, ok);
        // only the first length header decides the body size
        if (!cl_taken && ok) body_n = (num > 6) ? $urandom_range(0, 3) : int'(num);
        cl_taken = 1'b1;
      end else begin
        if (pick < 70) begin
          put_length_name($urandom_range(2));
        end else begin
          put($urandom_range(3) == 0 ? CH_COLON : rand_byte_not(CH_COLON, CH_CR, CH_LF));
          repeat ($urandom_range(0, 4)) put(rand_byte_not(CH_COLON, CH_CR, CH_LF));
        end
        put(CH_COLON);
        repeat ($urandom_range(0, 5)) put(rand_byte_not(CH_CR, CH_CR, CH_CR));
      end
      put(CH_CR);
      put(CH_LF);
    end
    put(CH_CR);
    put(CH_LF);
    repeat (body_n + $urandom_range(0, 2)) put(8'($urandom));
    // break some requests: a stray delimiter, a random byte or a restart
    if ($urandom_range(99) < 12) begin
      p = $urandom_range(1, req.size() - 1);
      case ($urandom_range(3))
        0: req[p] = {1'b0, CH_CR};
        1: req[p] = {1'b0, CH_LF};
        2: req[p] = {1'b0, 8'($urandom)};
        default: req[p] = {1'b1, 8'($urandom)};
      endcase
    end
    flush_req();
  endtask

  task automatic add_noise();
    repeat ($urandom_range(5, 15)) begin
      if ($urandom_range(15) == 0) put_restart();
      else put(8'($urandom));
    end
    flush_req();
  endtask

  // Idle percentage per side: sender 24 / receiver 81 in the first third,
  // the other way round in the second, no idling in the last.
  function automatic int idle_pct(input bit rx_side);
    if (n_sent < n_total / 3) return rx_side ? 81 : 24;
    if (n_sent < 2 * n_total / 3) return rx_side ? 24 : 81;
    return 0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one transfer per handshake, prediction taken at acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    hrf_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      clear_parser();
    end else begin
      if (s_tvalid && s_tready) begin
        tagged_bytes.push_back(frame_byte(s_tuser[0], s_tdata));
        n_sent <= n_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          item = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.data_byte;
          s_tuser  <= item.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    hrf_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tagged_bytes.size() == 0) begin
          $error("result transfer with no prediction pending");
          n_errors++;
        end else begin
          want = tagged_bytes.pop_front();
          check_field("byte_accepted", 32'(want.byte_accepted), 32'(m_tdata[0]));
          check_field("byte_out",      32'(want.byte_out),      32'(m_tdata[8:1]));
          check_field("status",        32'(want.status),        32'(m_tdata[10:9]));
          check_field("body_length",   want.body_length,        m_tdata[42:11]);
          check_field("length_known",  32'(want.length_known),  32'(m_tdata[43]));
          check_field("field_tag",     32'(want.field_tag),     32'(m_tuser));
          check_field("field_end",     32'(want.field_end),     32'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed items, random requests, reset, drain, verdict
  // ---------------------------------------------------------------------
  initial begin
    // CR as the very first byte is an error; the next byte is refused
    put_restart();
    put(CH_CR);
    put(8'hFF);
    // minimal request with extreme bytes in the method and an empty path;
    // the blank line's CR and LF close nothing and complete the request
    put_restart();
    put(8'h00);
    put(8'hFF);
    put(CH_SPACE);
    put(CH_SPACE);
    put(8'h56);
    put(CH_CR);
    put(CH_LF);
    put(CH_CR);
    put(CH_LF);
    put(8'h41);   // refused after completion
    flush_req();
    n_total = pending.size() + N_RANDOM;
    while (pending.size() < n_total) begin
      if ($urandom_range(99) < 8) add_noise();
      else add_request();
    end
    n_total = pending.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid || tagged_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hrf_pkg.sv
design/hrf_in_reg.sv
design/hrf_parser.sv
design/hrf_out_reg.sv
design/http_request_framer_core.sv
verif/testbench.sv
